FILE: sv/xue_pkg.sv
// Package for the XML / URL escape encoder.
// Holds the mode codes, the entity table and the hex digit helpers.
// Has no dependencies.
`default_nettype none

package xue_pkg;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_XML  = 2'd1,
        MODE_XML2 = 2'd2,
        MODE_URL  = 2'd3
    } mode_t;

    localparam int unsigned CharW    = 8;
    localparam int unsigned CountW   = 32;
    localparam int unsigned RunIdxW  = 4;   // run index 0..9
    localparam int unsigned MaxRun   = 10;

    localparam logic [2:0] ENT_QUOT = 3'd0;
    localparam logic [2:0] ENT_APOS = 3'd1;
    localparam logic [2:0] ENT_LT   = 3'd2;
    localparam logic [2:0] ENT_GT   = 3'd3;
    localparam logic [2:0] ENT_AMP  = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [CharW-1:0] data;
        logic             last;
        logic             clear;   // first byte of a string: restart the count
    } emit_req_t;

    function automatic logic [2:0] entity_len(input logic [2:0] idx);
        logic [2:0] len;
        case (idx)
            ENT_QUOT: len = 3'd6;
            ENT_APOS: len = 3'd6;
            ENT_LT:   len = 3'd4;
            ENT_GT:   len = 3'd4;
            default:  len = 3'd5;
        endcase
        return len;
    endfunction

    // Byte at position pos (0 = leftmost) of the entity selected by idx.
    function automatic logic [7:0] entity_byte(input logic [2:0] idx, input logic [2:0] pos);
        logic [47:0] s;
        logic [2:0]  len;
        logic [5:0]  sh;
        case (idx)
            ENT_QUOT: s = "&quot;";
            ENT_APOS: s = "&apos;";
            ENT_LT:   s = 48'("&lt;");
            ENT_GT:   s = 48'("&gt;");
            default:  s = 48'("&amp;");
        endcase
        len = entity_len(idx);
        sh  = {3'(len - 3'd1 - pos), 3'b000};
        return s[sh +: 8];
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'd0, d};
        end
        else
        begin
            c = 8'h41 + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/xue_encode.sv
// Combinational encoder: for one character and mode, gives the run length
// and the byte at a given position of the run. Depends on xue_pkg.
`default_nettype none

module xue_encode (
    input  wire logic [xue_pkg::CharW-1:0]   char_val,
    input  wire xue_pkg::mode_t              mode,
    input  wire logic [xue_pkg::RunIdxW-1:0] pos,
    output logic      [xue_pkg::CharW-1:0]   byte_val,
    output logic      [xue_pkg::RunIdxW-1:0] run_len
);

    logic       xml_hit;
    logic [2:0] ent_idx;
    logic [2:0] ent_len;
    logic       url_hit;
    logic [xue_pkg::RunIdxW-1:0] pos_m4;

    always_comb
    begin
        xml_hit = 1'b1;
        ent_idx = xue_pkg::ENT_AMP;
        case (char_val)
            8'h22:   ent_idx = xue_pkg::ENT_QUOT;
            8'h27:   ent_idx = xue_pkg::ENT_APOS;
            8'h3C:   ent_idx = xue_pkg::ENT_LT;
            8'h3E:   ent_idx = xue_pkg::ENT_GT;
            8'h26:   ent_idx = xue_pkg::ENT_AMP;
            default: xml_hit = 1'b0;
        endcase
    end

    assign ent_len = xue_pkg::entity_len(ent_idx);
    assign url_hit = (char_val >= 8'h20 && char_val <= 8'h2F)
                  || (char_val >= 8'h3A && char_val <= 8'h40);
    assign pos_m4  = pos - xue_pkg::RunIdxW'(4);

    always_comb
    begin
        byte_val = char_val;
        run_len  = xue_pkg::RunIdxW'(1);
        unique case (mode)
            xue_pkg::MODE_XML:
            begin
                if (xml_hit)
                begin
                    run_len  = {1'b0, ent_len};
                    byte_val = xue_pkg::entity_byte(ent_idx, pos[2:0]);
                end
            end
            xue_pkg::MODE_XML2:
            begin
                // The whole "&amp;" prefix, then the entity without its ampersand.
                if (xml_hit)
                begin
                    run_len = {1'b0, ent_len} + xue_pkg::RunIdxW'(4);
                    if (pos < xue_pkg::RunIdxW'(5))
                    begin
                        byte_val = xue_pkg::entity_byte(xue_pkg::ENT_AMP, pos[2:0]);
                    end
                    else
                    begin
                        byte_val = xue_pkg::entity_byte(ent_idx, pos_m4[2:0]);
                    end
                end
            end
            xue_pkg::MODE_URL:
            begin
                if (url_hit)
                begin
                    run_len = xue_pkg::RunIdxW'(3);
                    if (pos == xue_pkg::RunIdxW'(0))
                    begin
                        byte_val = 8'h25;
                    end
                    else if (pos == xue_pkg::RunIdxW'(1))
                    begin
                        byte_val = xue_pkg::hex_digit(char_val[7:4]);
                    end
                    else
                    begin
                        byte_val = xue_pkg::hex_digit(char_val[3:0]);
                    end
                end
            end
            default:
            begin
                byte_val = char_val;
                run_len  = xue_pkg::RunIdxW'(1);
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/xue_out_stage.sv
// Output register and saturating byte counter of the escape encoder.
// Depends on xue_pkg.
`default_nettype none

module xue_out_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire xue_pkg::emit_req_t           req,
    input  wire logic                         out_ready,
    output logic                              out_free,
    output logic                              out_valid,
    output logic [xue_pkg::CharW-1:0]         out_byte,
    output logic                              last_of_run,
    output logic [xue_pkg::CountW-1:0]        running_length
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [xue_pkg::CharW-1:0]     byte_reg;
    logic                          last_reg;
    logic [xue_pkg::CountW-1:0]    len_reg;
    logic [xue_pkg::CountW-1:0]    count_reg;
    logic [xue_pkg::CountW-1:0]    count_next;
    logic [xue_pkg::CountW-1:0]    count_base;
    logic                          load;

    assign out_free = !out_valid_reg || out_ready;
    assign load     = req.valid && out_free;

    assign count_base = req.clear ? '0 : count_reg;
    assign count_next = (count_base == '1) ? count_base : count_base + 1'b1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= req.data;
            last_reg <= req.last;
            len_reg  <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = byte_reg;
    assign last_of_run    = last_reg;
    assign running_length = len_reg;

endmodule

`default_nettype wire

FILE: sv/xml_url_escape_encoder_unit.sv
// Path: input register, combinational encode, output register. Throughput: one output
// byte per cycle while out_ready holds; a character whose encoding is 1 to 10 bytes holds
// the input register until its last byte is emitted, so plain characters flow one per
// cycle. The input register and its run index set that rate.
// Reset clears all valid flags, the byte count and sets the mode to pass-through.
// Top level of the XML / URL escape encoder; uses xue_pkg, xue_encode, xue_out_stage.
`default_nettype none

module xml_url_escape_encoder_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [xue_pkg::CharW-1:0]     char_in,
    input  wire logic                          start_of_string,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [xue_pkg::CharW-1:0]          out_byte,
    output logic                               last_of_run,
    output logic [xue_pkg::CountW-1:0]         running_length
);

    xue_pkg::mode_t                  mode_reg;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [xue_pkg::CharW-1:0]       s1_char_reg;
    logic                            s1_sos_reg;
    logic [xue_pkg::RunIdxW-1:0]     idx_reg;
    logic [xue_pkg::RunIdxW-1:0]     idx_next;
    logic [xue_pkg::CharW-1:0]       enc_byte;
    logic [xue_pkg::RunIdxW-1:0]     enc_len;
    logic                            out_free;
    logic                            emit;
    logic                            run_last;
    logic                            in_take;
    xue_pkg::emit_req_t              req;

    xue_encode u_encode (
        .char_val (s1_char_reg),
        .mode     (mode_reg),
        .pos      (idx_reg),
        .byte_val (enc_byte),
        .run_len  (enc_len)
    );

    assign run_last = (idx_reg == enc_len - 1'b1);
    assign emit     = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || (emit && run_last);
    assign in_take  = in_valid && in_ready;

    assign req.valid = s1_valid_reg;
    assign req.data  = enc_byte;
    assign req.last  = run_last;
    assign req.clear = s1_sos_reg && (idx_reg == '0);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        idx_next      = idx_reg;
        if (emit)
        begin
            idx_next = run_last ? '0 : idx_reg + 1'b1;
            if (run_last)
            begin
                s1_valid_next = 1'b0;
            end
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= xue_pkg::MODE_PASS;
            s1_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= xue_pkg::mode_t'(cfg_wdata);
            end
            s1_valid_reg <= s1_valid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_in;
            s1_sos_reg  <= start_of_string;
        end
    end

    xue_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .out_ready      (out_ready),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .running_length (running_length)
    );

endmodule

`default_nettype wire

FILE: sv/xue_checker.sv
// Port-level checks for the escape encoder, bound to the top level.
// Depends on xue_pkg for field widths.
`default_nettype none

module xue_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [xue_pkg::CharW-1:0]   out_byte,
    input wire logic                        last_of_run,
    input wire logic [xue_pkg::CountW-1:0]  running_length
);

    // A stalled byte keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(running_length))
        else $error("output request changed while stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> running_length != '0)
        else $error("running length is zero on a valid byte");

    // Bytes of one run follow each other without a gap and count up by one.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run && running_length != '1
            |=> out_valid && running_length == $past(running_length) + 1'b1)
        else $error("run continuation missing or miscounted");

    // While a byte that is not the last of its run is stalled, no new character may be taken.
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !last_of_run |-> !in_ready)
        else $error("input taken while a run is pending");

endmodule

bind xml_url_escape_encoder_unit xue_checker u_xue_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .running_length (running_length)
);

`default_nettype wire

FILE: sim/tb_xml_url_escape_encoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for xml_url_escape_encoder_unit: directed and random strings in
// all four escape modes, every output byte checked against an in-bench encoder.
// Depends on xue_pkg (sv/xue_pkg.sv) and the encoder RTL under sv/.

module tb_xml_url_escape_encoder_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] length;
    } enc_byte_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [1:0]  cfg_wdata       = 2'd0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  char_in         = 8'h00;
    logic        start_of_string = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [31:0] running_length;

    // In-bench copy of the encoder state.
    xue_pkg::mode_t cur_mode   = xue_pkg::MODE_PASS;
    logic [31:0]    byte_count = 32'd0;
    enc_byte_t      pending_bytes[$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit holdoff_req    = 1'b0;
    int holdoff_left   = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;
    int chars_sent     = 0;
    int bytes_checked  = 0;

    xml_url_escape_encoder_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_in         (char_in),
        .start_of_string (start_of_string),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .running_length  (running_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int len;
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(8, 30);
        end
        else
        begin
            len = $urandom_range(1, 3);
        end
        return len;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic string entity_name(input logic [7:0] c);
        string s;
        case (c)
            8'h22:   s = "quot";
            8'h27:   s = "apos";
            8'h3C:   s = "lt";
            8'h3E:   s = "gt";
            8'h26:   s = "amp";
            default: s = "";
        endcase
        return s;
    endfunction

    // Works out the bytes one character turns into and queues them with their
    // last flag and running length.
    task automatic encode_char(input logic [7:0] c, input logic sos);
        logic [7:0] run[$];
        string      ent;
        string      prefix;
        enc_byte_t  eb;
        int         i;
        ent    = entity_name(c);
        prefix = "&amp;";
        if (sos)
        begin
            byte_count = 32'd0;
        end
        if ((cur_mode == xue_pkg::MODE_XML || cur_mode == xue_pkg::MODE_XML2)
            && ent.len() != 0)
        begin
            if (cur_mode == xue_pkg::MODE_XML2)
            begin
                for (i = 0; i < prefix.len(); i++)
                begin
                    run.push_back(prefix[i]);
                end
            end
            else
            begin
                run.push_back("&");
            end
            for (i = 0; i < ent.len(); i++)
            begin
                run.push_back(ent[i]);
            end
            run.push_back(";");
        end
        else if (cur_mode == xue_pkg::MODE_URL &&
                 ((c >= 8'h20 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40)))
        begin
            run.push_back("%");
            run.push_back(hex_ascii(c[7:4]));
            run.push_back(hex_ascii(c[3:0]));
        end
        if (run.size() == 0)
        begin
            run.push_back(c);
        end
        for (i = 0; i < run.size(); i++)
        begin
            if (byte_count != 32'hFFFF_FFFF)
            begin
                byte_count = byte_count + 32'd1;
            end
            eb.data   = run[i];
            eb.last   = (i == run.size() - 1);
            eb.length = byte_count;
            pending_bytes.push_back(eb);
        end
    endtask

    // Picks a character, favouring ones the mode rewrites (pass mode: URL and XML ones).
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        int         sel;
        int         u;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            if (cur_mode == xue_pkg::MODE_URL || (cur_mode == xue_pkg::MODE_PASS && sel < 2))
            begin
                u = $urandom_range(0, 22);
                c = (u < 16) ? 8'(8'h20 + u) : 8'(8'h3A + u - 16);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       c = 8'h22;
                    1:       c = 8'h27;
                    2:       c = 8'h3C;
                    3:       c = 8'h3E;
                    default: c = 8'h26;
                endcase
            end
        end
        else if (sel < 8)
        begin
            c = 8'($urandom_range(8'h21, 8'h7E));
        end
        else
        begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    // Offers one character and returns at the edge where the request is taken.
    // Valid is left high so a back-to-back request keeps it up.
    task automatic send_char(input logic [7:0] c, input logic sos);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            gap = pick_gap();
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        char_in         <= c;
        start_of_string <= sos;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        encode_char(c, sos);
        chars_sent++;
    endtask

    task automatic send_string(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            send_char(pick_char(), i == 0);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input xue_pkg::mode_t m);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cur_mode = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_pass_through();
        // Mode is still at its reset value here.
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        send_char(8'h01, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h3C, 1'b0);
    endtask

    task automatic test_xml_entities();
        set_mode(xue_pkg::MODE_XML);
        send_char(8'h22, 1'b1);
        send_char(8'h27, 1'b0);
        send_char(8'h3C, 1'b0);
        send_char(8'h3E, 1'b0);
        send_char(8'h26, 1'b0);
    endtask

    task automatic test_double_xml();
        set_mode(xue_pkg::MODE_XML2);
        send_char(8'h26, 1'b1);
        send_char(8'h22, 1'b0);
        send_char(8'h27, 1'b0);
        send_char(8'h3C, 1'b0);
        send_char(8'h3E, 1'b0);
        send_char(8'h00, 1'b0);
    endtask

    task automatic test_url_percent();
        set_mode(xue_pkg::MODE_URL);
        send_char(8'h20, 1'b1);
        send_char(8'h2F, 1'b0);
        send_char(8'h30, 1'b0);
        send_char(8'h39, 1'b0);
        send_char(8'h3A, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h1F, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h00, 1'b0);
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // encoder backs up and drops in_ready.
    task automatic test_output_holdoff();
        set_mode(xue_pkg::MODE_XML2);
        send_gap_pct = 0;
        holdoff_req  = 1'b1;
        send_string(30);
        wait_idle();
        recv_stall_pct = 20;
    endtask

    // The sender drains everything mid-string; the count must carry on afterward.
    task automatic test_sender_pause();
        int i;
        set_mode(xue_pkg::MODE_URL);
        send_gap_pct = 10;
        send_string(10);
        wait_idle();
        for (i = 0; i < 10; i++)
        begin
            send_char(pick_char(), 1'b0);
        end
    endtask

    task automatic test_random_strings();
        xue_pkg::mode_t phase_modes[7];
        int             p;
        int             left;
        int             n;
        phase_modes = '{xue_pkg::MODE_URL, xue_pkg::MODE_XML, xue_pkg::MODE_XML2,
                        xue_pkg::MODE_PASS, xue_pkg::MODE_XML2, xue_pkg::MODE_URL,
                        xue_pkg::MODE_XML};
        for (p = 0; p < 7; p++)
        begin
            set_mode(phase_modes[p]);
            case (p % 3)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 30;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_gap_pct   = 10;
                    recv_stall_pct = 50;
                end
            endcase
            left = 45;
            while (left > 0)
            begin
                n = $urandom_range(1, 12);
                if (n > left)
                begin
                    n = left;
                end
                send_string(n);
                left -= n;
            end
        end
    endtask

    // Output side: random back-pressure, plus the long hold-off on request.
    always @(negedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < recv_stall_pct)
        begin
            stall_left = pick_gap() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        enc_byte_t eb;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output byte, expected none, got 0x%0h",
                         $time, out_byte);
            end
            else
            begin
                eb = pending_bytes.pop_front();
                check_field("out_byte", 32'(eb.data), 32'(out_byte));
                check_field("last_of_run", 32'(eb.last), 32'(last_of_run));
                check_field("running_length", eb.length, running_length);
                bytes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_xml_url_escape_encoder_unit: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pass_through();
        test_xml_entities();
        test_double_xml();
        test_url_percent();
        test_output_holdoff();
        test_sender_pause();
        test_random_strings();
        set_mode(xue_pkg::MODE_PASS);
        wait_idle();
        $display("Encoded %0d characters in pass, XML, double XML and URL modes,", chars_sent);
        $display("with hold-off and pause phases; %0d output bytes checked.", bytes_checked);
        if (mismatches == 0)
        begin
            $display("tb_xml_url_escape_encoder_unit: PASS");
        end
        else
        begin
            $display("tb_xml_url_escape_encoder_unit: FAIL");
        end
        $finish;
    end

endmodule
